// File: rtl/ctw_pkg.sv
// Shared types and constants for the compact-target-to-work core.
// No dependencies; imported by every module of the core.
`default_nettype none
package ctw_pkg;

  localparam int unsigned WORK_W  = 256;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned MANT_W  = 23;
  localparam int unsigned CMP_W   = 32;
  localparam int unsigned STEP_W  = 8;
  localparam logic [7:0]  EXP_BIAS = 8'd3;
  localparam logic [7:0]  EXP_SPAN = 8'd32;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORK_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INC,
    ST_START,
    ST_DIV,
    ST_FIN
  } ctw_state_t;

endpackage
`default_nettype wire

// File: rtl/ctw_decode.sv
// Compact word decoder: expands exponent and mantissa into a 256-bit target.
// Depends on ctw_pkg.
`default_nettype none
module ctw_decode
  import ctw_pkg::*;
(
  input  wire logic [CMP_W-1:0]  compact_bits,
  output logic      [WORK_W-1:0] target
);

  logic [7:0]        exponent;
  logic [WORK_W-1:0] mant_ext;
  logic [1:0]        rsh_bytes;
  logic [7:0]        lsh_bytes;

  assign exponent  = compact_bits[31:24];
  assign mant_ext  = {{(WORK_W-MANT_W){1'b0}}, compact_bits[MANT_W-1:0]};
  assign rsh_bytes = 2'(EXP_BIAS - exponent);
  assign lsh_bytes = exponent - EXP_BIAS;

  // Shift the mantissa by whole bytes; drop everything past bit 255
  always_comb begin
    if (exponent <= EXP_BIAS) begin
      target = mant_ext >> {rsh_bytes, 3'b000};
    end else if (lsh_bytes >= EXP_SPAN) begin
      target = '0;
    end else begin
      target = mant_ext << {lsh_bytes[4:0], 3'b000};
    end
  end

endmodule
`default_nettype wire

// File: rtl/ctw_div.sv
// Restoring divider of the all-ones 256-bit dividend by a 256-bit divisor.
// One quotient bit per cycle through a shared 258-bit subtractor. Depends on ctw_pkg.
`default_nettype none
module ctw_div
  import ctw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORK_W-1:0] divisor,
  output logic                   done,
  output logic      [WORK_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [WORK_W-1:0] rem;
  logic [WORK_W+1:0] diff;
  logic              take;

  // Shift in a one, trial-subtract with the carry-out bit of the remainder
  assign diff = {1'b0, rem[WORK_W-1], rem[WORK_W-2:0], 1'b1} - {2'b00, divisor};
  assign take = ~diff[WORK_W+1];

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= LAST_STEP;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? diff[WORK_W-1:0] : {rem[WORK_W-2:0], 1'b1};
      quotient <= {quotient[WORK_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: rtl/compact_target_to_work_core.sv
// Compact difficulty target to block work: top level with sequencer and output register.
// Depends on ctw_pkg, ctw_decode and ctw_div.
`default_nettype none
// A compact word is taken when cmp_valid is high and cmp_stall low; the core
// then holds cmp_stall high until the result is loaded into the output
// register. The work value is floor((2^256-1)/(target+1))+1, or zero for a
// zero target. From acceptance, an item passes through decode, increment
// and start, then the restoring divider, which yields one quotient bit per
// cycle on its 258-bit subtractor and then raises its done flag, and last
// the final increment and load, which waits while the output register
// still holds a stalled result. The next compact word can be taken in the
// cycle after the load. A zero target skips the divider. A new item may
// be taken while the previous result still waits in the output register.
module compact_target_to_work_core
  import ctw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmp_valid,
  output logic                   cmp_stall,
  input  wire logic [CMP_W-1:0]  compact_bits,
  output logic                   work_valid,
  input  wire logic              work_stall,
  output logic      [WORD_W-1:0] work_word0,
  output logic      [WORD_W-1:0] work_word1,
  output logic      [WORD_W-1:0] work_word2,
  output logic      [WORD_W-1:0] work_word3
);

  ctw_state_t        state, state_next;
  logic [CMP_W-1:0]  bits_reg;
  logic [WORK_W-1:0] dec_target;
  logic [WORK_W-1:0] target;
  logic [WORK_W-1:0] divisor;
  logic [WORK_W-1:0] quotient;
  logic [WORK_W-1:0] result;
  logic              skip;
  logic              div_start;
  logic              div_done;
  logic              accept;
  logic              load_out;

  ctw_decode u_decode (
    .compact_bits (bits_reg),
    .target       (dec_target)
  );

  ctw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign accept = cmp_valid & ~cmp_stall;
  assign result = skip ? '0 : quotient + WORK_W'(1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    cmp_stall  = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmp_stall = 1'b0;
        if (cmp_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: state_next = ST_INC;
      ST_INC:    state_next = ST_START;
      ST_START: begin
        if (skip || divisor == '0) begin
          state_next = ST_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!work_valid || !work_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture input, decoded target and divisor
  always_ff @(posedge clk) begin
    if (accept) begin
      bits_reg <= compact_bits;
    end
    if (state == ST_DECODE) begin
      target <= dec_target;
    end
    if (state == ST_INC) begin
      divisor <= target + WORK_W'(1);
      skip    <= (target == '0);
    end
    if (state == ST_START && divisor == '0) begin
      skip <= 1'b1;
    end
  end

  // Output valid: set on load, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (load_out) begin
      work_valid <= 1'b1;
    end else if (!work_stall) begin
      work_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      work_word0 <= result[63:0];
      work_word1 <= result[127:64];
      work_word2 <= result[191:128];
      work_word3 <= result[255:192];
    end
  end

endmodule
`default_nettype wire
